// File: hdl/http_response_header_parser_defines.svh
// Assertion helpers shared by the parser modules.
// Each module that asserts names its clock clk and its reset arst_n.
`ifndef HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH
`define HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH

// Checked only outside reset.
`define HRHP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define HRHP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/hrhp_pkg.sv
package hrhp_pkg;

	localparam int BYTE_W   = 8;
	localparam int CLASS_W  = 4;
	localparam int INDEX_W  = 8;
	localparam int DIGIT_W  = 4;
	localparam int STATUS_W = 16;
	localparam int LEN_W    = 12;
	localparam int ERR_W    = 4;
	localparam int PFX_LEN  = 5;

	// One request into the parser
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} hrhp_req_t;

	// One result out of the parser
	typedef struct packed {
		logic [CLASS_W-1:0]  byte_class;
		logic [INDEX_W-1:0]  header_index;
		logic [DIGIT_W-1:0]  major_ver;
		logic [DIGIT_W-1:0]  minor_ver;
		logic [STATUS_W-1:0] status_code;
		logic [LEN_W-1:0]    name_length;
		logic [LEN_W-1:0]    value_length;
		logic                header_complete;
		logic                message_done;
		logic [ERR_W-1:0]    error_code;
	} hrhp_rsp_t;

	// Classified byte handed from the front to the back
	typedef struct packed {
		logic [DIGIT_W-1:0] dig_val;
		logic               last;
		logic               is_dig;
		logic               is_major;
		logic               is_cr;
		logic               is_lf;
		logic               is_colon;
		logic               is_space;
		logic               is_dot;
		logic [PFX_LEN-1:0] pfx_hit;
	} hrhp_cls_t;

	// "HTTP/" prefix, one entry per position
	localparam logic [BYTE_W-1:0] PREFIX [PFX_LEN] = '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F};

endpackage

// File: hdl/hrhp_fifo.sv
`include "http_response_header_parser_defines.svh"

module hrhp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`HRHP_ASSERT(a_no_overflow, !(wr && full && !rd), "write into full queue")
	`HRHP_ASSERT(a_no_underflow, !(rd && empty), "read from empty queue")
	`HRHP_ASSERT_ALWAYS(a_count_range, !arst_n || count_q <= CNT_W'(DEPTH), "queue count out of range")

endmodule

// File: hdl/hrhp_front.sv
module hrhp_front #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hrhp_pkg::hrhp_req_t req,
	output logic                full,
	input  logic                rd,
	output hrhp_pkg::hrhp_cls_t cls,
	output logic                empty
);

	import hrhp_pkg::*;

	hrhp_cls_t cls_d;
	logic [BYTE_W-1:0] b;

	assign b = req.data_byte;

	// Byte classification
	always_comb begin
		cls_d          = '0;
		cls_d.dig_val  = b[DIGIT_W-1:0];
		cls_d.last     = req.last_byte;
		cls_d.is_dig   = (b >= 8'h30) && (b <= 8'h39);
		cls_d.is_major = (b >= 8'h31) && (b <= 8'h39);
		cls_d.is_cr    = (b == 8'h0D);
		cls_d.is_lf    = (b == 8'h0A);
		cls_d.is_colon = (b == 8'h3A);
		cls_d.is_space = (b == 8'h20);
		cls_d.is_dot   = (b == 8'h2E);
		for (int i = 0; i < PFX_LEN; i++) begin
			cls_d.pfx_hit[i] = (b == PREFIX[i]);
		end
	end

	// Queue towards the parser
	hrhp_fifo #(
		.WIDTH ($bits(hrhp_cls_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (push && !full),
		.wr_data (cls_d),
		.rd      (rd),
		.rd_data (cls),
		.full    (full),
		.empty   (empty)
	);

endmodule

// File: hdl/hrhp_back.sv
`include "http_response_header_parser_defines.svh"

module hrhp_back #(
	parameter int LENGTH_BITS       = 12,
	parameter int HEADER_INDEX_BITS = 8,
	parameter int QUEUE_DEPTH       = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hrhp_pkg::hrhp_cls_t cls,
	input  logic                cls_empty,
	output logic                cls_rd,
	input  logic                pop,
	output hrhp_pkg::hrhp_rsp_t rsp,
	output logic                empty
);

	import hrhp_pkg::*;

	// Parser phases
	localparam logic [3:0] PH_VERSION = 4'd0;
	localparam logic [3:0] PH_GAP     = 4'd1;
	localparam logic [3:0] PH_CODE    = 4'd2;
	localparam logic [3:0] PH_REASON  = 4'd3;
	localparam logic [3:0] PH_LINE    = 4'd4;
	localparam logic [3:0] PH_NAME    = 4'd5;
	localparam logic [3:0] PH_SEP     = 4'd6;
	localparam logic [3:0] PH_VALUE   = 4'd7;
	localparam logic [3:0] PH_BODY    = 4'd8;
	localparam logic [3:0] PH_ERROR   = 4'd9;

	// Byte classes
	localparam logic [CLASS_W-1:0] CL_VERSION = 4'd0;
	localparam logic [CLASS_W-1:0] CL_GAP     = 4'd1;
	localparam logic [CLASS_W-1:0] CL_DIGIT   = 4'd2;
	localparam logic [CLASS_W-1:0] CL_REASON  = 4'd3;
	localparam logic [CLASS_W-1:0] CL_NAME    = 4'd4;
	localparam logic [CLASS_W-1:0] CL_SEP     = 4'd5;
	localparam logic [CLASS_W-1:0] CL_VALUE   = 4'd6;
	localparam logic [CLASS_W-1:0] CL_EOL     = 4'd7;
	localparam logic [CLASS_W-1:0] CL_BODY    = 4'd8;
	localparam logic [CLASS_W-1:0] CL_IGNORED = 4'd9;

	// Error codes
	localparam logic [ERR_W-1:0] E_NONE      = 4'd0;
	localparam logic [ERR_W-1:0] E_SHORT_VER = 4'd1;
	localparam logic [ERR_W-1:0] E_PREFIX    = 4'd2;
	localparam logic [ERR_W-1:0] E_MAJOR     = 4'd3;
	localparam logic [ERR_W-1:0] E_DOT       = 4'd4;
	localparam logic [ERR_W-1:0] E_MINOR     = 4'd5;
	localparam logic [ERR_W-1:0] E_NO_STATUS = 4'd6;
	localparam logic [ERR_W-1:0] E_HDR_SHORT = 4'd7;
	localparam logic [ERR_W-1:0] E_NO_COLON  = 4'd8;
	localparam logic [ERR_W-1:0] E_NO_VALUE  = 4'd9;
	localparam logic [ERR_W-1:0] E_TRUNC     = 4'd10;
	localparam logic [ERR_W-1:0] E_BLANK     = 4'd11;

	localparam logic [2:0] LINE_SAT = 3'd5;

	// Parser state
	logic [3:0]                   phase_q;
	logic [2:0]                   vpos_q;
	logic [STATUS_W-1:0]          code_q;
	logic [DIGIT_W-1:0]           major_q, minor_q;
	logic [HEADER_INDEX_BITS-1:0] hdr_q;
	logic [LENGTH_BITS-1:0]       name_q, value_q;
	logic [2:0]                   bsls_q;
	logic                         pcr_q;
	logic [ERR_W-1:0]             err_q;

	// Next values
	logic [3:0]                   phase_d;
	logic [2:0]                   vpos_d;
	logic [STATUS_W-1:0]          code_d;
	logic [DIGIT_W-1:0]           major_d, minor_d;
	logic [HEADER_INDEX_BITS-1:0] hdr_d;
	logic [LENGTH_BITS-1:0]       name_d, value_d;
	logic [2:0]                   bsls_d;
	logic                         pcr_d;
	logic [ERR_W-1:0]             err_d, err_fin, err_out, ver_err;
	logic [CLASS_W-1:0]           cl;
	logic                         hc, in_line;

	logic [LENGTH_BITS-1:0]       name_inc, value_inc;
	logic [2:0]                   bsls_inc;
	logic [STATUS_W+3:0]          code_mul;
	logic [STATUS_W-1:0]          code_add;

	logic out_full, fire;
	hrhp_rsp_t rsp_d;

	assign fire   = !cls_empty && !out_full;
	assign cls_rd = fire;

	// Saturating helpers
	assign name_inc  = (&name_q)  ? name_q  : name_q + 1'b1;
	assign value_inc = (&value_q) ? value_q : value_q + 1'b1;
	assign bsls_inc  = (bsls_q < LINE_SAT) ? bsls_q + 1'b1 : bsls_q;
	assign code_mul  = {code_q, 3'b000} + {3'b000, code_q, 1'b0} + (STATUS_W + 4)'(cls.dig_val);
	assign code_add  = (code_mul > (STATUS_W + 4)'({STATUS_W{1'b1}})) ?
		{STATUS_W{1'b1}} : code_mul[STATUS_W-1:0];

	// One parser step
	always_comb begin
		phase_d = phase_q;
		vpos_d  = vpos_q;
		code_d  = code_q;
		major_d = major_q;
		minor_d = minor_q;
		name_d  = name_q;
		value_d = value_q;
		bsls_d  = bsls_q;
		pcr_d   = pcr_q;
		err_d   = err_q;
		ver_err = E_NONE;
		cl      = CL_IGNORED;
		hc      = 1'b0;
		in_line = 1'b0;

		unique case (phase_q)
			PH_VERSION: begin
				cl = CL_VERSION;
				if (vpos_q < 3'(PFX_LEN)) begin
					if (!cls.pfx_hit[vpos_q]) ver_err = E_PREFIX;
				end else if (vpos_q == 3'd5) begin
					if (cls.is_major) major_d = cls.dig_val;
					else ver_err = E_MAJOR;
				end else if (vpos_q == 3'd6) begin
					if (!cls.is_dot) ver_err = E_DOT;
				end else begin
					if (cls.is_dig) minor_d = cls.dig_val;
					else ver_err = E_MINOR;
				end
				if (ver_err != E_NONE && err_q == E_NONE) err_d = ver_err;
				if (vpos_q == 3'd7) begin
					vpos_d  = '0;
					phase_d = (err_d != E_NONE) ? PH_ERROR : PH_GAP;
				end else begin
					vpos_d = vpos_q + 1'b1;
				end
			end
			PH_GAP: begin
				cl = CL_GAP;
				if (cls.is_dig) begin
					cl      = CL_DIGIT;
					code_d  = code_add;
					phase_d = PH_CODE;
				end
			end
			PH_CODE: begin
				if (cls.is_dig) begin
					cl     = CL_DIGIT;
					code_d = code_add;
				end else if (cls.is_lf) begin
					cl      = CL_EOL;
					phase_d = PH_LINE;
				end else begin
					cl      = CL_REASON;
					phase_d = PH_REASON;
				end
			end
			PH_REASON: begin
				if (cls.is_lf) begin
					cl      = CL_EOL;
					phase_d = PH_LINE;
				end else begin
					cl = CL_REASON;
				end
			end
			PH_LINE: begin
				if (pcr_q) begin
					pcr_d = 1'b0;
					if (cls.is_lf) begin
						cl      = CL_EOL;
						phase_d = PH_BODY;
					end else begin
						err_d   = E_BLANK;
						phase_d = PH_ERROR;
					end
				end else if (cls.is_cr) begin
					cl    = CL_EOL;
					pcr_d = 1'b1;
				end else if (cls.is_lf) begin
					if (cls.last) begin
						cl = CL_EOL;
					end else begin
						err_d   = E_BLANK;
						phase_d = PH_ERROR;
					end
				end else begin
					// First byte of a header line
					in_line = 1'b1;
					value_d = '0;
					bsls_d  = 3'd1;
					if (cls.is_colon) begin
						cl      = CL_SEP;
						name_d  = '0;
						phase_d = PH_SEP;
					end else begin
						cl      = CL_NAME;
						name_d  = LENGTH_BITS'(1);
						phase_d = PH_NAME;
					end
				end
			end
			PH_NAME: begin
				in_line = 1'b1;
				bsls_d  = bsls_inc;
				if (cls.is_colon) begin
					cl      = CL_SEP;
					phase_d = PH_SEP;
				end else begin
					cl     = CL_NAME;
					name_d = name_inc;
				end
			end
			PH_SEP, PH_VALUE: begin
				in_line = 1'b1;
				bsls_d  = bsls_inc;
				if (phase_q == PH_SEP && cls.is_space) begin
					cl = CL_SEP;
				end else if (phase_q == PH_VALUE && pcr_q) begin
					pcr_d = 1'b0;
					if (cls.is_lf) begin
						cl      = CL_EOL;
						hc      = 1'b1;
						phase_d = PH_LINE;
					end else begin
						err_d   = E_BLANK;
						phase_d = PH_ERROR;
					end
				end else begin
					// Value byte or line end
					phase_d = PH_VALUE;
					if (cls.is_cr) begin
						cl    = CL_EOL;
						pcr_d = 1'b1;
					end else if (cls.is_lf) begin
						cl      = CL_EOL;
						hc      = 1'b1;
						phase_d = PH_LINE;
					end else begin
						cl      = CL_VALUE;
						value_d = value_inc;
					end
				end
			end
			PH_BODY: begin
				cl = CL_BODY;
			end
			default: begin
				cl = CL_IGNORED;
			end
		endcase

		hdr_d = (hc && !(&hdr_q)) ? hdr_q + 1'b1 : hdr_q;

		// Final error when the message ends here
		err_fin = err_d;
		if (cls.last) begin
			if (phase_d == PH_VERSION) begin
				err_fin = E_SHORT_VER;
			end else if (in_line && bsls_d < LINE_SAT) begin
				err_fin = E_HDR_SHORT;
			end else if (err_d == E_NONE) begin
				case (phase_d)
					PH_GAP, PH_CODE, PH_REASON: err_fin = E_NO_STATUS;
					PH_NAME:                    err_fin = E_NO_COLON;
					PH_SEP:                     err_fin = E_NO_VALUE;
					PH_VALUE, PH_LINE:          err_fin = E_TRUNC;
					default:                    err_fin = err_d;
				endcase
			end
		end
		err_out = (phase_d == PH_VERSION && !cls.last) ? E_NONE : err_fin;
	end

	// Result assembly
	always_comb begin
		rsp_d                 = '0;
		rsp_d.byte_class      = cl;
		rsp_d.header_index    = INDEX_W'(hdr_q);
		rsp_d.major_ver       = major_d;
		rsp_d.minor_ver       = minor_d;
		rsp_d.status_code     = code_d;
		rsp_d.name_length     = LEN_W'(name_d);
		rsp_d.value_length    = LEN_W'(value_d);
		rsp_d.header_complete = hc;
		rsp_d.message_done    = cls.last;
		rsp_d.error_code      = err_out;
	end

	// State update; the last byte returns the parser to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_VERSION;
			vpos_q  <= '0;
			code_q  <= '0;
			major_q <= '0;
			minor_q <= '0;
			hdr_q   <= '0;
			name_q  <= '0;
			value_q <= '0;
			bsls_q  <= '0;
			pcr_q   <= 1'b0;
			err_q   <= E_NONE;
		end else if (fire) begin
			if (cls.last) begin
				phase_q <= PH_VERSION;
				vpos_q  <= '0;
				code_q  <= '0;
				major_q <= '0;
				minor_q <= '0;
				hdr_q   <= '0;
				name_q  <= '0;
				value_q <= '0;
				bsls_q  <= '0;
				pcr_q   <= 1'b0;
				err_q   <= E_NONE;
			end else begin
				phase_q <= phase_d;
				vpos_q  <= vpos_d;
				code_q  <= code_d;
				major_q <= major_d;
				minor_q <= minor_d;
				hdr_q   <= hdr_d;
				name_q  <= name_d;
				value_q <= value_d;
				bsls_q  <= bsls_d;
				pcr_q   <= pcr_d;
				err_q   <= err_d;
			end
		end
	end

	// Result queue
	hrhp_fifo #(
		.WIDTH ($bits(hrhp_rsp_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_result_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (fire),
		.wr_data (rsp_d),
		.rd      (pop && !empty),
		.rd_data (rsp),
		.full    (out_full),
		.empty   (empty)
	);

	`HRHP_ASSERT(a_last_resets, fire && cls.last |=> phase_q == PH_VERSION && err_q == E_NONE, "not reset")
	`HRHP_ASSERT(a_error_held, phase_q == PH_ERROR |-> err_q != E_NONE, "error phase without code")
	`HRHP_ASSERT(a_vpos_phase, vpos_q != '0 |-> phase_q == PH_VERSION, "stray version position")

endmodule

// File: hdl/http_response_header_parser.sv
// A byte goes through the request queue and the parser into the result queue (empty low).
// Throughput: one byte per clock while results are popped; the parser step is combinational.
// A four-entry queue sits between classifier and parser, a two-entry queue holds results.
// Reset (arst_n low, asynchronous): both queues empty, parser in the version phase.
// The parser also returns to its reset state after each byte marked last_byte.
module http_response_header_parser #(
	parameter int LENGTH_BITS       = 12,
	parameter int HEADER_INDEX_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  hrhp_pkg::hrhp_req_t req,
	output logic                empty,
	input  logic                pop,
	output hrhp_pkg::hrhp_rsp_t rsp
);

	import hrhp_pkg::*;

	hrhp_cls_t cls;
	logic      cls_empty, cls_rd;

	// Classifier and request queue
	hrhp_front #(
		.QUEUE_DEPTH (4)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.req    (req),
		.full   (full),
		.rd     (cls_rd),
		.cls    (cls),
		.empty  (cls_empty)
	);

	// Parser and result queue
	hrhp_back #(
		.LENGTH_BITS       (LENGTH_BITS),
		.HEADER_INDEX_BITS (HEADER_INDEX_BITS),
		.QUEUE_DEPTH       (2)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls       (cls),
		.cls_empty (cls_empty),
		.cls_rd    (cls_rd),
		.pop       (pop),
		.rsp       (rsp),
		.empty     (empty)
	);

endmodule

// File: tb/hrhp_result_checker.sv
// Watches both queue sides of the parser, predicts every result and
// compares it field by field with what the parser hands out.
module hrhp_result_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  hrhp_pkg::hrhp_req_t req,
	input  logic                empty,
	input  logic                pop,
	input  hrhp_pkg::hrhp_rsp_t rsp,
	output int                  mismatches,
	output int                  pending_results,
	output int                  results_seen
);

	import hrhp_pkg::*;

	localparam int MAX_PRINTED = 200;

	localparam logic [7:0] CHR_LF    = 8'h0A;
	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_DOT   = 8'h2E;
	localparam logic [7:0] CHR_0     = 8'h30;
	localparam logic [7:0] CHR_1     = 8'h31;
	localparam logic [7:0] CHR_9     = 8'h39;
	localparam logic [7:0] CHR_COLON = 8'h3A;

	typedef enum logic [3:0] {
		PH_VERSION, PH_GAP, PH_CODE, PH_REASON, PH_LINE,
		PH_NAME, PH_SEP, PH_VALUE, PH_BODY, PH_ERROR
	} parse_phase_e;

	typedef enum logic [3:0] {
		CLS_VERSION, CLS_GAP, CLS_DIGIT, CLS_REASON, CLS_NAME,
		CLS_SEP, CLS_VALUE, CLS_LINE_END, CLS_BODY, CLS_IGNORED
	} byte_class_e;

	typedef enum logic [3:0] {
		ERR_NONE, ERR_SHORT_VERSION, ERR_PREFIX, ERR_MAJOR, ERR_DOT, ERR_MINOR,
		ERR_NO_STATUS_END, ERR_HEADER_SHORT, ERR_NO_COLON, ERR_NO_VALUE,
		ERR_TRUNCATED, ERR_BAD_BLANK
	} parse_err_e;

	// Shadow copy of the parser state
	parse_phase_e        parse_phase;
	logic [3:0]          ver_pos;
	logic [STATUS_W-1:0] code_acc;
	logic [DIGIT_W-1:0]  ver_major;
	logic [DIGIT_W-1:0]  ver_minor;
	logic [INDEX_W-1:0]  line_count;
	logic [LEN_W-1:0]    name_cnt;
	logic [LEN_W-1:0]    value_cnt;
	logic [2:0]          line_bytes;
	logic                cr_pending;
	logic [ERR_W-1:0]    err_latch;

	hrhp_rsp_t expected_rsp_q[$];

	function automatic void reset_parser();
		parse_phase = PH_VERSION;
		ver_pos     = '0;
		code_acc    = '0;
		ver_major   = '0;
		ver_minor   = '0;
		line_count  = '0;
		name_cnt    = '0;
		value_cnt   = '0;
		line_bytes  = '0;
		cr_pending  = 1'b0;
		err_latch   = ERR_NONE;
	endfunction

	function automatic logic is_dec(input logic [7:0] b);
		return b >= CHR_0 && b <= CHR_9;
	endfunction

	// decimal accumulate, sticks at all ones
	function automatic void add_digit(input logic [7:0] b);
		logic [31:0] v;
		v = {16'd0, code_acc} * 32'd10 + {28'd0, b[3:0]};
		code_acc = (v > 32'd65535) ? '1 : v[STATUS_W-1:0];
	endfunction

	function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	function automatic void set_error(input logic [ERR_W-1:0] e);
		err_latch   = e;
		parse_phase = PH_ERROR;
		cr_pending  = 1'b0;
	endfunction

	// first byte after colon and spaces, or any later value byte
	function automatic logic [CLASS_W-1:0] value_step(input logic [7:0] b, inout logic hc);
		parse_phase = PH_VALUE;
		if (b == CHR_CR) begin
			cr_pending = 1'b1;
			return CLS_LINE_END;
		end
		if (b == CHR_LF) begin
			hc = 1'b1;
			parse_phase = PH_LINE;
			return CLS_LINE_END;
		end
		value_cnt = sat_len(value_cnt);
		return CLS_VALUE;
	endfunction

	// One parser step: state update plus the result for this byte
	function automatic hrhp_rsp_t parse_byte(input hrhp_req_t r);
		logic [7:0]         b;
		logic               last;
		logic [CLASS_W-1:0] cls;
		logic [ERR_W-1:0]   e;
		logic [INDEX_W-1:0] idx;
		logic               hc;
		logic               in_line;
		hrhp_rsp_t          o;
		b       = r.data_byte;
		last    = r.last_byte;
		cls     = CLS_IGNORED;
		idx     = line_count;
		hc      = 1'b0;
		in_line = 1'b0;

		case (parse_phase)
		PH_VERSION: begin
			// bad version bytes are remembered, shown from the eighth byte on
			e   = ERR_NONE;
			cls = CLS_VERSION;
			if (ver_pos < PFX_LEN) begin
				if (b != PREFIX[ver_pos]) e = ERR_PREFIX;
			end else if (ver_pos == PFX_LEN) begin
				if (b >= CHR_1 && b <= CHR_9) ver_major = b[3:0];
				else e = ERR_MAJOR;
			end else if (ver_pos == PFX_LEN + 1) begin
				if (b != CHR_DOT) e = ERR_DOT;
			end else begin
				if (is_dec(b)) ver_minor = b[3:0];
				else e = ERR_MINOR;
			end
			if (e != ERR_NONE && err_latch == ERR_NONE) err_latch = e;
			if (ver_pos == 4'd7) begin
				ver_pos = '0;
				parse_phase = (err_latch != ERR_NONE) ? PH_ERROR : PH_GAP;
			end else begin
				ver_pos = ver_pos + 1'b1;
			end
		end
		PH_GAP: begin
			cls = CLS_GAP;
			if (is_dec(b)) begin
				cls = CLS_DIGIT;
				add_digit(b);
				parse_phase = PH_CODE;
			end
		end
		PH_CODE: begin
			if (is_dec(b)) begin
				cls = CLS_DIGIT;
				add_digit(b);
			end else if (b == CHR_LF) begin
				cls = CLS_LINE_END;
				parse_phase = PH_LINE;
			end else begin
				cls = CLS_REASON;
				parse_phase = PH_REASON;
			end
		end
		PH_REASON: begin
			if (b == CHR_LF) begin
				cls = CLS_LINE_END;
				parse_phase = PH_LINE;
			end else begin
				cls = CLS_REASON;
			end
		end
		PH_LINE: begin
			// line start: blank line, lone LF, or a new header name
			if (cr_pending) begin
				cr_pending = 1'b0;
				if (b == CHR_LF) begin
					cls = CLS_LINE_END;
					parse_phase = PH_BODY;
				end else begin
					cls = CLS_IGNORED;
					set_error(ERR_BAD_BLANK);
				end
			end else if (b == CHR_CR) begin
				cls = CLS_LINE_END;
				cr_pending = 1'b1;
			end else if (b == CHR_LF) begin
				if (last) begin
					cls = CLS_LINE_END;
				end else begin
					cls = CLS_IGNORED;
					set_error(ERR_BAD_BLANK);
				end
			end else begin
				in_line    = 1'b1;
				name_cnt   = '0;
				value_cnt  = '0;
				line_bytes = '0;
				if (b == CHR_COLON) begin
					cls = CLS_SEP;
					parse_phase = PH_SEP;
				end else begin
					cls = CLS_NAME;
					name_cnt = sat_len('0);
					parse_phase = PH_NAME;
				end
			end
		end
		PH_NAME: begin
			in_line = 1'b1;
			if (b == CHR_COLON) begin
				cls = CLS_SEP;
				parse_phase = PH_SEP;
			end else begin
				cls = CLS_NAME;
				name_cnt = sat_len(name_cnt);
			end
		end
		PH_SEP: begin
			in_line = 1'b1;
			if (b == CHR_SPACE) cls = CLS_SEP;
			else cls = value_step(b, hc);
		end
		PH_VALUE: begin
			in_line = 1'b1;
			if (cr_pending) begin
				cr_pending = 1'b0;
				if (b == CHR_LF) begin
					cls = CLS_LINE_END;
					hc = 1'b1;
					parse_phase = PH_LINE;
				end else begin
					cls = CLS_IGNORED;
					set_error(ERR_BAD_BLANK);
				end
			end else begin
				cls = value_step(b, hc);
			end
		end
		PH_BODY: cls = CLS_BODY;
		default: cls = CLS_IGNORED;
		endcase

		if (in_line && line_bytes < 3'd5) line_bytes = line_bytes + 1'b1;
		if (hc && line_count != '1) line_count = line_count + 1'b1;

		// final byte decides the closing error
		if (last) begin
			if (parse_phase == PH_VERSION) begin
				err_latch = ERR_SHORT_VERSION;
			end else if (in_line && line_bytes < 3'd5) begin
				err_latch = ERR_HEADER_SHORT;
			end else if (err_latch == ERR_NONE) begin
				case (parse_phase)
				PH_GAP, PH_CODE, PH_REASON: err_latch = ERR_NO_STATUS_END;
				PH_NAME:                    err_latch = ERR_NO_COLON;
				PH_SEP:                     err_latch = ERR_NO_VALUE;
				PH_VALUE, PH_LINE:          err_latch = ERR_TRUNCATED;
				default: ;
				endcase
			end
		end

		o.byte_class      = cls;
		o.header_index    = idx;
		o.major_ver       = ver_major;
		o.minor_ver       = ver_minor;
		o.status_code     = code_acc;
		o.name_length     = name_cnt;
		o.value_length    = value_cnt;
		o.header_complete = hc;
		o.message_done    = last;
		o.error_code      = (parse_phase == PH_VERSION && !last) ? ERR_NONE : err_latch;

		if (last) reset_parser();
		return o;
	endfunction

	// print capped so a broken parser cannot flood the log
	task automatic report(input string what);
		if (mismatches < MAX_PRINTED)
			$display("[%0t] result %0d: %s", $time, results_seen, what);
		mismatches++;
	endtask

	// Compare first, then predict: a request never shows as a result in its own cycle
	always @(posedge clk or negedge arst_n) begin
		hrhp_rsp_t want;
		if (!arst_n) begin
			expected_rsp_q.delete();
			reset_parser();
			mismatches = 0;
			pending_results <= 0;
			results_seen <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_rsp_q.size() == 0) begin
					report("result with no request waiting");
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.byte_class !== want.byte_class)
						report($sformatf("byte_class %0d, expected %0d",
							rsp.byte_class, want.byte_class));
					if (rsp.header_index !== want.header_index)
						report($sformatf("header_index %0d, expected %0d",
							rsp.header_index, want.header_index));
					if (rsp.major_ver !== want.major_ver)
						report($sformatf("major_ver %0d, expected %0d",
							rsp.major_ver, want.major_ver));
					if (rsp.minor_ver !== want.minor_ver)
						report($sformatf("minor_ver %0d, expected %0d",
							rsp.minor_ver, want.minor_ver));
					if (rsp.status_code !== want.status_code)
						report($sformatf("status_code %0d, expected %0d",
							rsp.status_code, want.status_code));
					if (rsp.name_length !== want.name_length)
						report($sformatf("name_length %0d, expected %0d",
							rsp.name_length, want.name_length));
					if (rsp.value_length !== want.value_length)
						report($sformatf("value_length %0d, expected %0d",
							rsp.value_length, want.value_length));
					if (rsp.header_complete !== want.header_complete)
						report($sformatf("header_complete %0b, expected %0b",
							rsp.header_complete, want.header_complete));
					if (rsp.message_done !== want.message_done)
						report($sformatf("message_done %0b, expected %0b",
							rsp.message_done, want.message_done));
					if (rsp.error_code !== want.error_code)
						report($sformatf("error_code %0d, expected %0d",
							rsp.error_code, want.error_code));
				end
				results_seen <= results_seen + 1;
			end
			if (push && !full) expected_rsp_q.push_back(parse_byte(req));
			pending_results <= expected_rsp_q.size();
		end
	end

endmodule

// File: tb/tb_http_response_header_parser.sv
module tb_http_response_header_parser;

	import hrhp_pkg::*;

	localparam int RANDOM_ITEMS = 680;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 1000000;

	localparam logic [7:0] LF    = 8'h0A;
	localparam logic [7:0] CR    = 8'h0D;
	localparam logic [7:0] SP    = 8'h20;
	localparam logic [7:0] DOT   = 8'h2E;
	localparam logic [7:0] COLON = 8'h3A;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      pop    = 1'b0;
	hrhp_req_t req    = '0;
	logic      full;
	logic      empty;
	hrhp_rsp_t rsp;

	int mismatches;
	int pending_results;
	int results_seen;

	logic [7:0] msg[$];
	hrhp_req_t  stim_q[$];
	int         directed_n;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	http_response_header_parser uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.req    (req),
		.empty  (empty),
		.pop    (pop),
		.rsp    (rsp)
	);

	hrhp_result_checker rsp_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.req             (req),
		.empty           (empty),
		.pop             (pop),
		.rsp             (rsp),
		.mismatches      (mismatches),
		.pending_results (pending_results),
		.results_seen    (results_seen)
	);

	// --- message building ---

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
	endtask

	task automatic add_bytes(input int n, input bit printable,
			input logic [7:0] skip_a, input logic [7:0] skip_b);
		logic [7:0] b;
		repeat (n) begin
			b = printable ? 8'($urandom_range(8'h21, 8'h7E)) : 8'($urandom_range(0, 255));
			if (b == skip_a || b == skip_b) b ^= 8'h40;
			msg.push_back(b);
		end
	endtask

	// CR LF mostly, bare LF now and then
	task automatic end_line();
		if ($urandom_range(0, 5) != 0) msg.push_back(CR);
		msg.push_back(LF);
	endtask

	// flush the scratch message into the request stream, last mark on its final byte
	task automatic commit_msg();
		hrhp_req_t r;
		for (int i = 0; i < msg.size(); i++) begin
			r.data_byte = msg[i];
			r.last_byte = (i == msg.size() - 1);
			stim_q.push_back(r);
		end
		msg.delete();
	endtask

	// mostly well-formed response; negative lengths pick at random per line
	task automatic build_response(input int n_hdr, input int name_n, input int value_n);
		logic [7:0] b;
		int         n;
		push_str("HTTP/");
		msg.push_back(8'($urandom_range(8'h31, 8'h39)));
		msg.push_back(DOT);
		msg.push_back(8'($urandom_range(8'h30, 8'h39)));

		// gap before the code: space, nothing, or odd non-digit bytes
		case ($urandom_range(0, 19))
		0: ;
		1, 2: begin
			n = $urandom_range(1, 3);
			repeat (n) begin
				b = 8'($urandom_range(0, 255));
				if (b >= 8'h30 && b <= 8'h39) b ^= 8'h40;
				msg.push_back(b);
			end
		end
		default: msg.push_back(SP);
		endcase

		// status code, long runs to saturate now and then
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 7) : 3;
		repeat (n) msg.push_back(8'($urandom_range(8'h30, 8'h39)));

		if ($urandom_range(0, 4) != 0) begin
			msg.push_back(SP);
			add_bytes($urandom_range(0, 10), 1'b1, LF, LF);
		end else begin
			add_bytes($urandom_range(0, 6), 1'b0, LF, LF);
		end
		end_line();

		for (int h = 0; h < n_hdr; h++) begin
			add_bytes((name_n < 0) ? $urandom_range(1, 12) : name_n,
				$urandom_range(0, 6) != 0, COLON, COLON);
			msg.push_back(COLON);
			repeat ($urandom_range(0, 2)) msg.push_back(SP);
			add_bytes((value_n < 0) ? $urandom_range(0, 10) : value_n,
				$urandom_range(0, 4) != 0, CR, LF);
			end_line();
		end

		// blank line; a bare LF here is a broken one
		if ($urandom_range(0, 19) != 0) msg.push_back(CR);
		msg.push_back(LF);
		repeat ($urandom_range(0, 12)) msg.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic build_stimulus();
		int kind;
		int cut;
		int pos;
		int base;

		// directed: byte extremes as whole messages, bad version, lone LF at the end
		msg.push_back(8'h00);
		commit_msg();
		msg.push_back(8'hFF);
		commit_msg();
		push_str("XTTP/0?9");
		commit_msg();
		push_str("HTTP/1.1 2\n\n");
		commit_msg();
		directed_n = stim_q.size();

		base = stim_q.size();
		while (stim_q.size() - base < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 95) begin
				build_response($urandom_range(0, 5), -1, -1);
			end else begin
				repeat ($urandom_range(1, 20)) msg.push_back(8'($urandom_range(0, 255)));
			end
			// corrupt one byte, version bytes half the time
			if (kind >= 80 && kind < 95) begin
				pos = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, msg.size() - 1);
				msg[pos] = 8'($urandom_range(0, 255));
			end
			// cut short anywhere
			if ((kind >= 65 && kind < 80) || (kind >= 80 && kind < 95 && $urandom_range(0, 1))) begin
				cut = $urandom_range(0, msg.size() - 1);
				while (msg.size() > cut + 1) void'(msg.pop_back());
			end
			commit_msg();
		end
	endtask

	// --- request side: bursts and gaps, two pauses until drained ---
	task automatic send_all();
		int burst;
		int gap;
		int drain_at;
		burst    = 0;
		drain_at = stim_q.size() * 2 / 3;
		for (int i = 0; i < stim_q.size(); i++) begin
			if (i == directed_n || i == drain_at) begin
				push <= 1'b0;
				@(posedge clk);
				while (pending_results != 0) @(posedge clk);
			end
			if (burst <= 0) begin
				if ($urandom_range(0, 3) == 0) begin
					burst = $urandom_range(50, 200);
					gap   = 0;
				end else begin
					burst = $urandom_range(1, 8);
					gap   = $urandom_range(0, 8);
				end
				if (gap > 0) begin
					push <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst--;
			push <= 1'b1;
			req  <= stim_q[i];
			do @(posedge clk); while (full);
		end
		push <= 1'b0;
	endtask

	// --- result side: stall patterns, one long hold to fill the parser ---
	initial begin
		int  mode;
		int  run;
		bit  held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			if (!held && results_seen >= 200) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			run  = $urandom_range(5, 60);
			repeat (run) begin
				case (mode)
				0:       pop <= 1'b1;
				1:       pop <= 1'($urandom_range(0, 1));
				2:       pop <= ($urandom_range(0, 7) == 0);
				default: pop <= ($urandom_range(0, 3) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// run limit
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("** http_response_header_parser: FAILED **");
		$finish;
	end

	// main sequence: reset, stimulus, drain, verdict
	initial begin
		build_stimulus();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_all();
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results == 0)
			$display("** http_response_header_parser: PASSED **");
		else
			$display("** http_response_header_parser: FAILED **");
		$finish;
	end

endmodule
